// File: rtl/core/bdlp_pkg.sv
// Shared types and constants for the push-button debouncer with long-press detection.
// No dependencies; bdlp_tick and the top level import this package.
package bdlp_pkg;

	// Event codes carried on the result channel.
	typedef enum logic [1:0] {
		EV_SHORT        = 2'd0,
		EV_LONG         = 2'd1,
		EV_RELEASE_LONG = 2'd2
	} evt_code_t;

	// Events caused by one tick: how many, and their codes in order.
	typedef struct packed {
		logic [1:0] count;
		evt_code_t  first;
		evt_code_t  second;
	} evt_pair_t;

	// One entry of the result queue.
	typedef struct packed {
		evt_code_t code;
		logic      last;
	} evt_word_t;

	localparam int          STABLE_TICKS_DEF = 2;
	localparam logic [7:0]  LPT_RESET        = 8'd40;
	localparam int          EVT_FIFO_DEPTH   = 4;
	localparam int          HOLD_W           = 10;

endpackage

// File: rtl/core/bdlp_in_if.sv
// Input channel carrying one raw pin sample per word.
// Standalone; no package dependency.
interface bdlp_in_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink   (input valid, input pin_level, output ready);
endinterface

// File: rtl/core/bdlp_out_if.sv
// Result channel carrying one button event per word.
// Standalone; no package dependency.
interface bdlp_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_code;
	logic       last;

	modport source (output valid, output event_code, output last, input ready);
	modport sink   (input valid, input event_code, input last, output ready);
endinterface

// File: rtl/core/bdlp_cfg_if.sv
// Configuration write channel for the long-press limit register.
// Standalone; no package dependency.
interface bdlp_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] long_press_ticks;

	modport source (output valid, output long_press_ticks, input ready);
	modport sink   (input valid, input long_press_ticks, output ready);
endinterface

// File: rtl/core/bdlp_tick.sv
// Per-tick debounce and hold-timer state with the event decode for one sample.
// Depends on bdlp_pkg.
module bdlp_tick
	import bdlp_pkg::*;
#(
	parameter int STABLE_TICKS = STABLE_TICKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       pin_level,
	input  logic [7:0] long_press_ticks,
	output evt_pair_t  evts
);

	localparam logic [1:0] STABLE_THR = 2'(STABLE_TICKS);
	localparam logic [1:0] CNT_MAX    = 2'd3;

	logic                     prev_q;
	logic [1:0]               cnt_q;
	logic                     deb_q;
	logic signed [HOLD_W-1:0] hold_q;

	logic                     pressed;
	logic [1:0]               cnt_n;
	logic signed [HOLD_W-1:0] hold_inc;
	logic signed [HOLD_W-1:0] hold_adv;
	logic signed [HOLD_W-1:0] hold_n;
	logic                     long_fire;
	logic                     level_edge;
	logic                     release_ev;
	evt_code_t                rel_code;

	// Debounce counter, hold timer and event decode for the sample in hand.
	always_comb begin
		pressed = ~pin_level;
		if (pressed == prev_q) begin
			cnt_n = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 2'd1;
		end else begin
			cnt_n = '0;
		end

		// The hold timer advances before the level check, so one tick may
		// give a long press and then its release.
		hold_inc  = hold_q + HOLD_W'(1);
		hold_adv  = hold_q;
		long_fire = 1'b0;
		if (hold_q > 0) begin
			if (hold_inc > $signed({2'b00, long_press_ticks})) begin
				long_fire = 1'b1;
				hold_adv  = -HOLD_W'(1);
			end else begin
				hold_adv = hold_inc;
			end
		end

		level_edge = (cnt_n >= STABLE_THR) && (pressed != deb_q);
		release_ev = level_edge && !pressed;
		rel_code   = (hold_adv < 0) ? EV_RELEASE_LONG : EV_SHORT;

		if (level_edge) begin
			hold_n = pressed ? HOLD_W'(1) : '0;
		end else begin
			hold_n = hold_adv;
		end

		evts.count  = {1'b0, long_fire} + {1'b0, release_ev};
		evts.first  = long_fire ? EV_LONG : rel_code;
		evts.second = rel_code;
	end

	// State registers move on each processed sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			cnt_q  <= '0;
			deb_q  <= 1'b0;
			hold_q <= '0;
		end else if (step) begin
			prev_q <= pressed;
			cnt_q  <= cnt_n;
			if (level_edge) begin
				deb_q <= pressed;
			end
			hold_q <= hold_n;
		end
	end

endmodule

// File: rtl/core/button_debounce_long_press.sv
// Push-button debouncer with long-press detection, top level, built on bdlp_pkg and bdlp_tick.
// Path: input register, then the tick decode written into the event queue, then the queue head.
// Throughput: one sample per cycle while the event queue is empty; otherwise a sample waits
// until the queued words, counting two for a sample in the input register, are at most two.
// Results leave at one word per cycle while the receiver is ready.
// Reset (arst_n, asynchronous): debounce state released, hold timer idle, queue empty, limit 40.
module button_debounce_long_press
	import bdlp_pkg::*;
#(
	parameter int STABLE_TICKS = STABLE_TICKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bdlp_in_if.sink     sample,
	bdlp_out_if.source  events,
	bdlp_cfg_if.sink    cfg
);

	localparam int PTR_W = $clog2(EVT_FIFO_DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam logic [CNT_W:0] ROOM_LIMIT = (CNT_W + 1)'(EVT_FIFO_DEPTH - 2);

	logic [7:0]       lpt_q;
	logic             pin_s1;
	logic             valid_s1;
	evt_pair_t        evts;
	evt_word_t        fifo_q [EVT_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       push_n;
	logic             pop;
	logic [CNT_W:0]   reserved;
	logic             in_take;

	// Configuration register; the user must write it only while idle, the block itself does not enforce this.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpt_q <= LPT_RESET;
		end else if (cfg.valid) begin
			lpt_q <= cfg.long_press_ticks;
		end
	end

	// Accept a sample only when the queue can take two words from each item in flight.
	assign reserved     = {1'b0, cnt_q} + (valid_s1 ? (CNT_W + 1)'(2) : '0);
	assign sample.ready = (reserved <= ROOM_LIMIT);
	assign in_take      = sample.valid && sample.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pin_s1 <= sample.pin_level;
		end
	end

	bdlp_tick #(
		.STABLE_TICKS (STABLE_TICKS)
	) u_tick (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (valid_s1),
		.pin_level        (pin_s1),
		.long_press_ticks (lpt_q),
		.evts             (evts)
	);

	// Event queue: up to two words written per cycle, one read.
	assign push_n = valid_s1 ? evts.count : 2'd0;
	assign pop    = events.valid && events.ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= '{code: evts.first, last: (push_n == 2'd1)};
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= '{code: evts.second, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	// Result channel driven from the queue head.
	assign events.valid      = (cnt_q != '0);
	assign events.event_code = fifo_q[rd_ptr_q].code;
	assign events.last       = fifo_q[rd_ptr_q].last;

	// The queue never holds more words than it has entries.
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(EVT_FIFO_DEPTH))
		else $error("event queue overflow");

	// A sample is taken only with room left for its two possible words.
	a_room_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (cnt_q <= CNT_W'(EVT_FIFO_DEPTH - 2)))
		else $error("sample accepted without queue room");

	// Two events from one tick are always a long press and its release.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && evts.count == 2'd2) |->
		(evts.first == EV_LONG && evts.second == EV_RELEASE_LONG))
		else $error("bad order of paired events");

	// A word not marked last is always followed by its partner in the queue.
	a_last_partner: assert property (@(posedge clk) disable iff (!arst_n)
		(events.valid && !events.last) |-> (cnt_q >= CNT_W'(2)))
		else $error("first of a pair without its partner");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for button_debounce_long_press: drives pin samples and limit writes,
// predicts the event words in a small scoreboard and checks every word that leaves the block.
// Depends on bdlp_pkg and the three channel interfaces of the RTL.
module tb_top
	import bdlp_pkg::*;
();

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 30;

	// Debounce and hold-timer predictor with the queue of event words still owed by the block.
	class event_scoreboard;
		logic [7:0]              limit;
		logic                    prev_pressed;
		logic [1:0]              stable_cnt;
		logic                    deb_pressed;
		logic signed [HOLD_W-1:0] hold;
		evt_word_t               owed_q[$];
		int                      errors;
		int                      samples;
		int                      words_seen;
		int                      double_ticks;
		int                      code_seen[3];

		function new();
			limit        = LPT_RESET;
			prev_pressed = 1'b0;
			stable_cnt   = 2'd0;
			deb_pressed  = 1'b0;
			hold         = '0;
			errors       = 0;
			samples      = 0;
			words_seen   = 0;
			double_ticks = 0;
		endfunction

		function void set_limit(logic [7:0] value);
			limit = value;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// Advance the debounce state by one tick and queue the words it causes.
		function void note_sample(logic pin);
			logic      pressed;
			evt_code_t codes[2];
			int        n;
			evt_word_t w;
			pressed = ~pin;
			n = 0;
			if (pressed == prev_pressed) begin
				if (stable_cnt < 2'd3)
					stable_cnt = stable_cnt + 2'd1;
			end else begin
				stable_cnt = 2'd0;
			end
			prev_pressed = pressed;

			// The hold timer moves before the edge check, so one tick may give two words.
			if (hold > 0) begin
				hold = hold + 10'sd1;
				if (hold > $signed({2'b00, limit})) begin
					codes[n] = EV_LONG;
					n++;
					hold = -10'sd1;
				end
			end

			if (stable_cnt >= STABLE_TICKS_DEF && pressed != deb_pressed) begin
				deb_pressed = pressed;
				if (pressed) begin
					hold = 10'sd1;
				end else begin
					codes[n] = (hold < 0) ? EV_RELEASE_LONG : EV_SHORT;
					n++;
					hold = '0;
				end
			end

			for (int i = 0; i < n; i++) begin
				w.code = codes[i];
				w.last = (i == n - 1);
				owed_q.insert(owed_q.size(), w);
			end
			if (n == 2)
				double_ticks++;
			samples++;
		endfunction

		// Compare one accepted event word with the oldest one owed.
		function void check_event(logic [1:0] code, logic last);
			evt_word_t w;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected event word, expected none, got code %0d last %0b",
						$time, code, last);
				return;
			end
			w = owed_q.pop_front();
			words_seen++;
			if (code !== w.code || last !== w.last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: event mismatch, expected code %0d last %0b, got code %0d last %0b",
						$time, w.code, w.last, code, last);
			end else begin
				code_seen[code]++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles = 0;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   cur_limit;
	logic cur_pin;

	event_scoreboard board;

	bdlp_in_if  sample_if();
	bdlp_out_if event_if();
	bdlp_cfg_if cfg_if();

	button_debounce_long_press DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if),
		.events (event_if),
		.cfg    (cfg_if)
	);

	// Free-running clock, 8 ns period.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Cycle counter that ends a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d words still owed.",
				cycles, board.pending());
			$display("FAIL");
			$finish;
		end
	end

	// The event receiver stalls at random at the current rate.
	always @(negedge clk) begin
		event_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Every event word accepted by the receiver is checked at once.
	always @(posedge clk) begin
		if (arst_n && event_if.valid && event_if.ready)
			board.check_event(event_if.event_code, event_if.last);
	end

	// Offer one pin sample, with random idle cycles ahead of it, and wait until it is taken.
	task automatic send_sample(input logic pin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_if.valid <= 1'b0;
			@(negedge clk);
		end
		sample_if.valid     <= 1'b1;
		sample_if.pin_level <= pin;
		@(posedge clk);
		while (!sample_if.ready)
			@(posedge clk);
		board.note_sample(pin);
		@(negedge clk);
	endtask

	// Drive a short fixed pattern, oldest sample in the top bit.
	task automatic send_pattern(input logic [31:0] bits, input int n);
		for (int i = n - 1; i >= 0; i--)
			send_sample(bits[i]);
		cur_pin = bits[0];
	endtask

	// Hold the sender back until every owed word has arrived and the pipeline has emptied.
	task automatic wait_drained();
		sample_if.valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Write the long-press limit; the block must be idle.
	task automatic write_limit(input logic [7:0] value);
		cfg_if.valid            <= 1'b1;
		cfg_if.long_press_ticks <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		board.set_limit(value);
		cur_limit = value;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Random runs of equal levels: single-sample bounces, short runs, holds of at most the limit
	// plus four or 30, and holds well past it. The sender drains the block once at pause_at.
	// A run is cut short when the phase has sent all of its samples.
	task automatic random_phase(input int n_items, input int pause_at);
		int sent;
		int run;
		int r;
		int span;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				run = 1;
			end else if (r < 60) begin
				run = $urandom_range(2, 6);
			end else if (r < 85) begin
				span = (cur_limit < 30) ? cur_limit + 4 : 30;
				run = $urandom_range(3, span);
			end else begin
				run = $urandom_range(cur_limit + 3, cur_limit + 8);
			end
			cur_pin = ~cur_pin;
			repeat (run) begin
				if (sent < n_items) begin
					if (sent == pause_at)
						wait_drained();
					send_sample(cur_pin);
					sent++;
				end
			end
		end
	endtask

	// Main sequence: reset, directed patterns, then random phases under three idle mixes.
	initial begin
		int rand_limit;
		arst_n                  = 1'b0;
		sample_if.valid         = 1'b0;
		sample_if.pin_level     = 1'b1;
		cfg_if.valid            = 1'b0;
		cfg_if.long_press_ticks = LPT_RESET;
		event_if.ready          = 1'b0;
		send_idle_pct           = 13;
		recv_idle_pct           = 45;
		cur_limit               = LPT_RESET;
		cur_pin                 = 1'b1;
		board                   = new();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Limit zero: a bounce, then a hold that fires on the first tick after acceptance.
		write_limit(8'd0);
		send_pattern(32'b010000111, 9);
		wait_drained();

		// Limit three: the long press and the release land on the same tick.
		write_limit(8'd3);
		send_pattern(32'b000111, 6);
		wait_drained();

		// Largest limit: a brief press gives a short-press word.
		write_limit(8'd255);
		send_pattern(32'b000111, 6);
		wait_drained();

		// Sender idles lightly, receiver heavily, at the reset limit.
		write_limit(LPT_RESET);
		random_phase(220, -1);
		wait_drained();

		// The other way round, at the largest limit, with one full drain part way.
		send_idle_pct = 45;
		recv_idle_pct = 13;
		write_limit(8'd255);
		random_phase(180, 90);
		wait_drained();

		// No idling on either side, at a small random limit.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		rand_limit = $urandom_range(1, 12);
		write_limit(rand_limit[7:0]);
		random_phase(230, -1);
		wait_drained();

		$display("Sent %0d pin samples over limits 0, 3, 255, 40 and %0d under three stall mixes.",
			board.samples, rand_limit);
		$display("Checked %0d event words: %0d short, %0d long, %0d release after long; %0d double ticks.",
			board.words_seen, board.code_seen[EV_SHORT], board.code_seen[EV_LONG],
			board.code_seen[EV_RELEASE_LONG], board.double_ticks);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/bdlp_pkg.sv
rtl/core/bdlp_in_if.sv
rtl/core/bdlp_out_if.sv
rtl/core/bdlp_cfg_if.sv
rtl/core/bdlp_tick.sv
rtl/core/button_debounce_long_press.sv
bench/tb_top.sv
